>>> rtl/tras_pkg.sv
`timescale 1ns / 1ps

package tras_pkg;

    // Fixed field widths
    localparam int DATA_W = 8;
    localparam int CFG_W  = 10;
    localparam int TIME_W = 32;
    localparam int LEN_W  = 16;

    // Default sizing
    localparam int DEF_RING_DEPTH  = 1024;
    localparam int DEF_CHUNK_BYTES = 32;

    // Input item codes
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_WRITE  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ANSWER  = 2'd0;
    localparam logic [1:0] KIND_SENT    = 2'd1;
    localparam logic [1:0] KIND_WREPORT = 2'd2;
    localparam logic [1:0] KIND_CREPORT = 2'd3;

    // Admission answers
    localparam logic [2:0] STATUS_ACCEPT    = 3'd0;
    localparam logic [2:0] STATUS_NO_SPACE  = 3'd1;
    localparam logic [2:0] STATUS_BP        = 3'd2;
    localparam logic [2:0] STATUS_THROTTLED = 3'd3;
    localparam logic [2:0] STATUS_RESERVE   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_RESERVE = 2'd0;
    localparam logic [1:0] CFG_IDX_HIGH    = 2'd1;
    localparam logic [1:0] CFG_IDX_LOW     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] critical_reserve;
        logic [CFG_W-1:0] high_water;
        logic [CFG_W-1:0] low_water;
    } t_cfg;

    typedef struct packed {
        logic pending_nz;
        logic blocked;
        logic throttle;
    } t_flags;

endpackage

>>> rtl/tras_ring_ram.sv
`timescale 1ns / 1ps

module tras_ring_ram #(
    parameter int DEPTH = tras_pkg::DEF_RING_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tras_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tras_pkg::DATA_W-1:0] o_rdata
);
    import tras_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tras_admit.sv
`timescale 1ns / 1ps

module tras_admit #(
    parameter int RING_DEPTH = tras_pkg::DEF_RING_DEPTH,
    localparam int PW = $clog2(RING_DEPTH)
) (
    input  tras_pkg::t_cfg              i_cfg,
    input  tras_pkg::t_flags            i_flags,
    input  logic [PW-1:0]               i_queued,
    input  logic [PW-1:0]               i_queued_post,
    input  logic [tras_pkg::LEN_W-1:0]  i_length,
    input  logic                        i_critical,
    output logic [2:0]                  o_status,
    output logic                        o_throttle_next
);
    import tras_pkg::*;

    localparam int AW = ((PW > LEN_W) ? PW : LEN_W) + 2;
    localparam logic [AW-1:0] CAPACITY = AW'(RING_DEPTH - 1);

    logic [AW-1:0] w_q;
    logic [AW-1:0] w_qp;
    logic [AW-1:0] w_len;
    logic [AW-1:0] w_res;
    logic [AW-1:0] w_hw;
    logic [AW-1:0] w_lw;
    logic [AW-1:0] w_limit;
    logic [AW-1:0] w_sum;

    assign w_q   = AW'(i_queued);
    assign w_qp  = AW'(i_queued_post);
    assign w_len = AW'(i_length);
    assign w_res = AW'(i_cfg.critical_reserve);
    assign w_hw  = AW'(i_cfg.high_water);
    assign w_lw  = AW'(i_cfg.low_water);
    assign w_sum = w_q + w_len;

    // Space left to normal packets after the critical reserve
    assign w_limit = (w_res >= CAPACITY) ? CAPACITY : CAPACITY - w_res;

    // Rank the admission answers
    always_comb begin
        if (i_flags.pending_nz || (w_len > CAPACITY - w_q)) begin
            o_status = STATUS_NO_SPACE;
        end else if (i_critical) begin
            o_status = STATUS_ACCEPT;
        end else if (i_flags.blocked) begin
            o_status = STATUS_BP;
        end else if (i_flags.throttle) begin
            o_status = STATUS_THROTTLED;
        end else if ((w_hw != '0) && (w_sum >= w_hw)) begin
            o_status = STATUS_THROTTLED;
        end else if (w_sum > w_limit) begin
            o_status = STATUS_RESERVE;
        end else begin
            o_status = STATUS_ACCEPT;
        end
    end

    // Apply watermark hysteresis to the level after the item
    always_comb begin
        if (w_hw == '0) begin
            o_throttle_next = 1'b0;
        end else if (!i_flags.throttle && (w_qp >= w_hw)) begin
            o_throttle_next = 1'b1;
        end else if (i_flags.throttle && (w_qp <= w_lw)) begin
            o_throttle_next = 1'b0;
        end else begin
            o_throttle_next = i_flags.throttle;
        end
    end

endmodule

>>> rtl/tx_ring_admission_scheduler.sv
`timescale 1ns / 1ps

// Transmit byte ring with watermark admission control.
// Input: an item is transferred when start is high and busy is low. func
// selects header (admission request), packet byte, write attempt or clear.
// Configuration: i_cfg_we writes register i_cfg_addr (0 critical reserve,
// 1 high water, 2 low water) at once; only write while the block is idle.
// Output: each result is shown for one cycle with o_strobe high; o_last
// marks the final result of an item. The receiver cannot stall.
// Timing: a header, clear or empty write attempt answers in the cycle after
// its transfer and busy stays low. A packet byte has no result and busy
// stays low, so bytes stream at one per cycle. A write attempt that sends
// N bytes (N up to CHUNK_BYTES) reads the ring memory one byte per cycle:
// each byte shows from the registered read port, the report follows the
// last byte, and busy is high in the send and report states. The single
// read port of the ring memory sets that rate.
// Reset (synchronous, active low) empties the ring, clears the throttle
// and blocked state and the registers; ring contents stay undefined.
module tx_ring_admission_scheduler #(
    parameter int RING_DEPTH  = tras_pkg::DEF_RING_DEPTH,
    parameter int CHUNK_BYTES = tras_pkg::DEF_CHUNK_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [15:0]                 i_length,
    input  logic                        i_priority_req,
    input  logic [7:0]                  i_data_byte,
    input  logic [15:0]                 i_request_limit,
    input  logic [15:0]                 i_sink_space,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [tras_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                        o_strobe,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_out_byte,
    output logic [2:0]                  o_status,
    output logic [5:0]                  o_taken_len,
    output logic [5:0]                  o_accepted_len,
    output logic [9:0]                  o_flushed_len,
    output logic [9:0]                  o_queued_bytes,
    output logic                        o_throttle_on,
    output logic                        o_backpressure_on,
    output logic                        o_backpressure_ended,
    output logic [31:0]                 o_backpressure_ms,
    output logic                        o_last
);
    import tras_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(CHUNK_BYTES + 1);
    localparam int AW = ((PW > LEN_W) ? PW : LEN_W) + 2;
    localparam logic [AW-1:0] CHUNK = AW'(CHUNK_BYTES);

    // State
    t_state            r_state, n_state;
    t_cfg              r_cfg;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_pend, n_pend;
    logic              r_thr, n_thr;
    logic              r_blk, n_blk;
    logic [TIME_W-1:0] r_bstart, n_bstart;

    // Send sequencer
    logic [PW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_rep_req, n_rep_req;
    logic [CW-1:0]     r_rep_act, n_rep_act;
    logic              r_rep_ended, n_rep_ended;
    logic [TIME_W-1:0] r_rep_ms, n_rep_ms;

    // Output register
    logic              r_ov, n_ov;
    logic [1:0]        r_okind, n_okind;
    logic [2:0]        r_ostatus, n_ostatus;
    logic [5:0]        r_oreq, n_oreq;
    logic [5:0]        r_oact, n_oact;
    logic [9:0]        r_odrop, n_odrop;
    logic [9:0]        r_oq, n_oq;
    logic              r_othr, n_othr;
    logic              r_oblk, n_oblk;
    logic              r_oended, n_oended;
    logic [TIME_W-1:0] r_oms, n_oms;
    logic              r_olast, n_olast;

    // Datapath
    logic              w_accept;
    logic [PW-1:0]     w_q;
    logic [AW-1:0]     w_q_ext;
    logic [PW-1:0]     w_q_post;
    logic [AW-1:0]     w_qa_ext;
    logic [CW-1:0]     w_n1;
    logic [CW-1:0]     w_n;
    logic [CW-1:0]     w_act;
    logic [TIME_W-1:0] w_elapsed;
    t_flags            w_flags;
    logic [2:0]        w_adm_status;
    logic              w_thr_next;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [DATA_W-1:0] w_rdata;

    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && !busy;
    assign w_q       = r_wp - r_rp;
    assign w_q_ext   = AW'(w_q);
    assign w_qa_ext  = AW'(n_wp - n_rp);
    assign w_elapsed = i_now_ms - r_bstart;

    // Size the chunk: budget, then queued level, then sink space
    assign w_n1  = (AW'(i_request_limit) < CHUNK) ? CW'(i_request_limit) : CW'(CHUNK_BYTES);
    assign w_n   = (w_q_ext < AW'(w_n1)) ? CW'(w_q) : w_n1;
    assign w_act = (AW'(i_sink_space) < AW'(w_n)) ? CW'(i_sink_space) : w_n;

    // Level that the throttle sees after this item
    assign w_q_post = (i_func == FUNC_BYTE) ? (w_q + PW'(1)) : (w_q - PW'(w_act));

    assign w_flags.pending_nz = (r_pend != '0);
    assign w_flags.blocked    = r_blk;
    assign w_flags.throttle   = r_thr;

    tras_admit #(
        .RING_DEPTH (RING_DEPTH)
    ) u_admit (
        .i_cfg           (r_cfg),
        .i_flags         (w_flags),
        .i_queued        (w_q),
        .i_queued_post   (w_q_post),
        .i_length        (i_length),
        .i_critical      (i_priority_req),
        .o_status        (w_adm_status),
        .o_throttle_next (w_thr_next)
    );

    assign w_mem_we = w_accept && (i_func == FUNC_BYTE) && w_flags.pending_nz;
    assign w_mem_re = (r_state == ST_SEND);

    tras_ring_ram #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_data_byte),
        .i_re    (w_mem_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode items, advance the sequencer, load the output register
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_pend      = r_pend;
        n_thr       = r_thr;
        n_blk       = r_blk;
        n_bstart    = r_bstart;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_rep_req   = r_rep_req;
        n_rep_act   = r_rep_act;
        n_rep_ended = r_rep_ended;
        n_rep_ms    = r_rep_ms;
        n_ov        = 1'b0;
        n_okind     = r_okind;
        n_ostatus   = '0;
        n_oreq      = '0;
        n_oact      = '0;
        n_odrop     = '0;
        n_oq        = '0;
        n_othr      = 1'b0;
        n_oblk      = 1'b0;
        n_oended    = 1'b0;
        n_oms       = '0;
        n_olast     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_func)
                        FUNC_HEADER: begin
                            n_ov    = 1'b1;
                            n_okind = KIND_ANSWER;
                            if (i_length != '0) begin
                                n_ostatus = w_adm_status;
                                if (w_adm_status == STATUS_ACCEPT) begin
                                    n_pend = PW'(i_length);
                                end
                            end
                            n_oq   = w_q_ext[9:0];
                            n_othr = r_thr;
                            n_oblk = r_blk;
                        end
                        FUNC_BYTE: begin
                            if (w_flags.pending_nz) begin
                                n_wp   = r_wp + PW'(1);
                                n_pend = r_pend - PW'(1);
                                if (r_pend == PW'(1)) begin
                                    n_thr = w_thr_next;
                                end
                            end
                        end
                        FUNC_WRITE: begin
                            n_rep_req   = w_n;
                            n_rep_act   = w_act;
                            n_rep_ended = 1'b0;
                            n_rep_ms    = '0;
                            if (w_n != '0) begin
                                if (w_act == '0) begin
                                    if (!r_blk) begin
                                        n_blk    = 1'b1;
                                        n_bstart = i_now_ms;
                                    end else begin
                                        n_rep_ms = w_elapsed;
                                    end
                                end else begin
                                    if (r_blk) begin
                                        n_rep_ms    = w_elapsed;
                                        n_rep_ended = 1'b1;
                                        n_blk       = 1'b0;
                                        n_bstart    = '0;
                                    end
                                    n_rp    = r_rp + PW'(w_act);
                                    n_thr   = w_thr_next;
                                    n_addr  = r_rp;
                                    n_cnt   = w_act;
                                    n_state = ST_SEND;
                                end
                            end
                            // Nothing to send: report at once
                            if (w_act == '0) begin
                                n_ov     = 1'b1;
                                n_okind  = KIND_WREPORT;
                                n_oreq   = 6'(w_n);
                                n_oms    = n_rep_ms;
                                n_oq     = w_q_ext[9:0];
                                n_othr   = r_thr;
                                n_oblk   = n_blk;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_wp     = '0;
                            n_rp     = '0;
                            n_pend   = '0;
                            n_thr    = 1'b0;
                            n_blk    = 1'b0;
                            n_bstart = '0;
                            n_ov     = 1'b1;
                            n_okind  = KIND_CREPORT;
                            n_odrop  = w_q_ext[9:0];
                        end
                    endcase
                end
            end
            ST_SEND: begin
                // One ring read per cycle; byte shows with the read data
                n_addr  = r_addr + PW'(1);
                n_cnt   = r_cnt - CW'(1);
                n_ov    = 1'b1;
                n_okind = KIND_SENT;
                n_olast = 1'b0;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                n_ov     = 1'b1;
                n_okind  = KIND_WREPORT;
                n_oreq   = 6'(r_rep_req);
                n_oact   = 6'(r_rep_act);
                n_oended = r_rep_ended;
                n_oms    = r_rep_ms;
                n_oq     = w_qa_ext[9:0];
                n_othr   = r_thr;
                n_oblk   = r_blk;
                n_state  = ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_pend   <= '0;
            r_thr    <= 1'b0;
            r_blk    <= 1'b0;
            r_bstart <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_pend   <= n_pend;
            r_thr    <= n_thr;
            r_blk    <= n_blk;
            r_bstart <= n_bstart;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_IDX_RESERVE: r_cfg.critical_reserve <= i_cfg_wdata;
                    CFG_IDX_HIGH:    r_cfg.high_water       <= i_cfg_wdata;
                    CFG_IDX_LOW:     r_cfg.low_water        <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Hold sequencer payload and output fields
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_cnt       <= n_cnt;
        r_rep_req   <= n_rep_req;
        r_rep_act   <= n_rep_act;
        r_rep_ended <= n_rep_ended;
        r_rep_ms    <= n_rep_ms;
        r_okind     <= n_okind;
        r_ostatus   <= n_ostatus;
        r_oreq      <= n_oreq;
        r_oact      <= n_oact;
        r_odrop     <= n_odrop;
        r_oq        <= n_oq;
        r_othr      <= n_othr;
        r_oblk      <= n_oblk;
        r_oended    <= n_oended;
        r_oms       <= n_oms;
        r_olast     <= n_olast;
    end

    assign o_strobe             = r_ov;
    assign o_kind               = r_okind;
    assign o_out_byte           = (r_okind == KIND_SENT) ? w_rdata : '0;
    assign o_status             = r_ostatus;
    assign o_taken_len          = r_oreq;
    assign o_accepted_len       = r_oact;
    assign o_flushed_len        = r_odrop;
    assign o_queued_bytes       = r_oq;
    assign o_throttle_on        = r_othr;
    assign o_backpressure_on    = r_oblk;
    assign o_backpressure_ended = r_oended;
    assign o_backpressure_ms    = r_oms;
    assign o_last               = r_olast;

`ifndef SYNTH
    a_send_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND) |-> (r_cnt != '0))
        else $error("send state entered with no bytes left");

    a_report_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |=> (o_strobe && (o_kind == KIND_WREPORT) && o_last))
        else $error("write report missing after last sent byte");

    a_sent_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_SENT)) |-> !o_last)
        else $error("sent byte marked as final result");

    a_block_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_blk) |-> $past(start && !busy && (i_func == FUNC_WRITE)))
        else $error("blocked flag set outside a write attempt");
`endif

endmodule

>>> test/tras_checker.sv
`timescale 1ns / 1ps

module tras_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_length,
    input  logic        i_priority_req,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_request_limit,
    input  logic [15:0] i_sink_space,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        o_strobe,
    input  logic [1:0]  o_kind,
    input  logic [7:0]  o_out_byte,
    input  logic [2:0]  o_status,
    input  logic [5:0]  o_taken_len,
    input  logic [5:0]  o_accepted_len,
    input  logic [9:0]  o_flushed_len,
    input  logic [9:0]  o_queued_bytes,
    input  logic        o_throttle_on,
    input  logic        o_backpressure_on,
    input  logic        o_backpressure_ended,
    input  logic [31:0] o_backpressure_ms,
    input  logic        o_last,
    output int          results_owed,
    output int          mismatch_count
);
    import tras_pkg::*;

    localparam int          DEPTH = DEF_RING_DEPTH;
    localparam int          CHUNK = DEF_CHUNK_BYTES;
    localparam int unsigned ROOM  = DEPTH - 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [5:0]  requested;
        logic [5:0]  actual;
        logic [9:0]  dropped;
        logic [9:0]  queued;
        logic        throttle;
        logic        blocked;
        logic        ended;
        logic [31:0] blocked_ms;
        logic        last;
    } t_ring_result;

    t_ring_result results_due[$];
    t_ring_result oldest;

    // Shadow of the ring and its admission state
    logic [7:0]  ring_bytes [DEPTH];
    logic [9:0]  wr_ptr;
    logic [9:0]  rd_ptr;
    logic        throttled;
    logic        blocked;
    logic [31:0] blocked_since;
    int unsigned owed_bytes;
    logic [9:0]  reserve;
    logic [9:0]  high_mark;
    logic [9:0]  low_mark;

    function automatic int unsigned ring_level();
        logic [9:0] diff;
        diff = wr_ptr - rd_ptr;
        return diff;
    endfunction

    // Apply the high/low watermark hysteresis
    task automatic refresh_throttle();
        int unsigned q;
        q = ring_level();
        if (high_mark == 0) begin
            throttled = 1'b0;
        end else if (!throttled && q >= high_mark) begin
            throttled = 1'b1;
        end else if (throttled && q <= low_mark) begin
            throttled = 1'b0;
        end
    endtask

    function automatic logic [2:0] admission_answer(int unsigned len, logic crit);
        int unsigned q;
        int unsigned limit;
        q = ring_level();
        limit = (reserve >= ROOM) ? ROOM : ROOM - reserve;
        if (owed_bytes != 0 || len > ROOM - q) return STATUS_NO_SPACE;
        if (crit) return STATUS_ACCEPT;
        if (blocked) return STATUS_BP;
        if (throttled) return STATUS_THROTTLED;
        if (high_mark != 0 && q + len >= high_mark) return STATUS_THROTTLED;
        if (q + len > limit) return STATUS_RESERVE;
        return STATUS_ACCEPT;
    endfunction

    // Queue a closing result that carries the ring state after the item
    task automatic push_report(logic [1:0] kind, logic [2:0] status, int unsigned req,
                               int unsigned act, int unsigned drop, logic ended,
                               logic [31:0] span);
        t_ring_result r;
        r            = '0;
        r.kind       = kind;
        r.status     = status;
        r.requested  = req;
        r.actual     = act;
        r.dropped    = drop;
        r.queued     = ring_level();
        r.throttle   = throttled;
        r.blocked    = blocked;
        r.ended      = ended;
        r.blocked_ms = span;
        r.last       = 1'b1;
        results_due.push_back(r);
    endtask

    // Work out what the transferred item produces and advance the shadow state
    task automatic apply_item();
        t_ring_result sent_res;
        logic [2:0]   answer;
        int unsigned  take;
        int unsigned  sent;
        int unsigned  q;
        logic [31:0]  span;
        logic         ended;
        span  = '0;
        ended = 1'b0;
        case (i_func)
            FUNC_HEADER: begin
                answer = STATUS_ACCEPT;
                if (i_length != 0) begin
                    answer = admission_answer(i_length, i_priority_req);
                    if (answer == STATUS_ACCEPT) owed_bytes = i_length;
                end
                push_report(KIND_ANSWER, answer, 0, 0, 0, 1'b0, '0);
            end
            FUNC_BYTE: begin
                // drop bytes that belong to no admitted packet
                if (owed_bytes != 0) begin
                    ring_bytes[wr_ptr] = i_data_byte;
                    wr_ptr = wr_ptr + 1'b1;
                    owed_bytes--;
                    if (owed_bytes == 0) refresh_throttle();
                end
            end
            FUNC_WRITE: begin
                q    = ring_level();
                take = CHUNK;
                if (take > i_request_limit) take = i_request_limit;
                if (take > q) take = q;
                sent = (take < i_sink_space) ? take : i_sink_space;
                if (take != 0) begin
                    if (sent == 0) begin
                        if (!blocked) begin
                            blocked       = 1'b1;
                            blocked_since = i_now_ms;
                        end else begin
                            span = i_now_ms - blocked_since;
                        end
                    end else begin
                        for (int i = 0; i < sent; i++) begin
                            sent_res          = '0;
                            sent_res.kind     = KIND_SENT;
                            sent_res.out_byte = ring_bytes[rd_ptr];
                            rd_ptr            = rd_ptr + 1'b1;
                            results_due.push_back(sent_res);
                        end
                        if (blocked) begin
                            span          = i_now_ms - blocked_since;
                            blocked       = 1'b0;
                            blocked_since = '0;
                            ended         = 1'b1;
                        end
                        refresh_throttle();
                    end
                end
                push_report(KIND_WREPORT, '0, take, sent, 0, ended, span);
            end
            default: begin
                q             = ring_level();
                wr_ptr        = '0;
                rd_ptr        = '0;
                blocked       = 1'b0;
                blocked_since = '0;
                throttled     = 1'b0;
                owed_bytes    = 0;
                push_report(KIND_CREPORT, '0, 0, 0, q, 1'b0, '0);
            end
        endcase
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    // Compare on each result transfer, then take configuration and input transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr         = '0;
            rd_ptr         = '0;
            throttled      = 1'b0;
            blocked        = 1'b0;
            blocked_since  = '0;
            owed_bytes     = 0;
            reserve        = '0;
            high_mark      = '0;
            low_mark       = '0;
            mismatch_count = 0;
        end else begin
            if (o_strobe === 1'b1) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("result with nothing due, kind", o_kind, '0);
                end else begin
                    oldest = results_due.pop_front();
                    check_field("kind", o_kind, oldest.kind);
                    check_field("out_byte", o_out_byte, oldest.out_byte);
                    check_field("status", o_status, oldest.status);
                    check_field("taken_len", o_taken_len, oldest.requested);
                    check_field("accepted_len", o_accepted_len, oldest.actual);
                    check_field("flushed_len", o_flushed_len, oldest.dropped);
                    check_field("queued_bytes", o_queued_bytes, oldest.queued);
                    check_field("throttle_on", o_throttle_on, oldest.throttle);
                    check_field("backpressure_on", o_backpressure_on, oldest.blocked);
                    check_field("backpressure_ended", o_backpressure_ended, oldest.ended);
                    check_field("backpressure_ms", o_backpressure_ms, oldest.blocked_ms);
                    check_field("last", o_last, oldest.last);
                end
            end else if (o_strobe !== 1'b0) begin
                flag_mismatch("strobe", o_strobe, '0);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_IDX_RESERVE: reserve   = i_cfg_wdata;
                    CFG_IDX_HIGH:    high_mark = i_cfg_wdata;
                    CFG_IDX_LOW:     low_mark  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (start && busy === 1'b0) apply_item();
        end
        results_owed = results_due.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tras_pkg::*;

    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
    localparam int         PHASE_OPS     = 9;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [1:0]  i_func          = FUNC_HEADER;
    logic [15:0] i_length        = '0;
    logic        i_priority_req  = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic [15:0] i_request_limit = '0;
    logic [15:0] i_sink_space    = '0;
    logic [31:0] i_now_ms        = '0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = CFG_IDX_RESERVE;
    logic [9:0]  i_cfg_wdata     = '0;

    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic [5:0]  o_taken_len;
    logic [5:0]  o_accepted_len;
    logic [9:0]  o_flushed_len;
    logic [9:0]  o_queued_bytes;
    logic        o_throttle_on;
    logic        o_backpressure_on;
    logic        o_backpressure_ended;
    logic [31:0] o_backpressure_ms;
    logic        o_last;

    int          results_owed;
    int          mismatch_count;
    int          burst_left = 0;
    logic        gaps_on    = 1'b1;
    logic [31:0] clock_ms   = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tx_ring_admission_scheduler dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_func               (i_func),
        .i_length             (i_length),
        .i_priority_req       (i_priority_req),
        .i_data_byte          (i_data_byte),
        .i_request_limit      (i_request_limit),
        .i_sink_space         (i_sink_space),
        .i_now_ms             (i_now_ms),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .o_strobe             (o_strobe),
        .o_kind               (o_kind),
        .o_out_byte           (o_out_byte),
        .o_status             (o_status),
        .o_taken_len          (o_taken_len),
        .o_accepted_len       (o_accepted_len),
        .o_flushed_len        (o_flushed_len),
        .o_queued_bytes       (o_queued_bytes),
        .o_throttle_on        (o_throttle_on),
        .o_backpressure_on    (o_backpressure_on),
        .o_backpressure_ended (o_backpressure_ended),
        .o_backpressure_ms    (o_backpressure_ms),
        .o_last               (o_last)
    );

    tras_checker ring_checker (.*);

    // Scramble the payload while no transfer is offered
    task automatic idle_cycle();
        @(negedge i_clk);
        start           = 1'b0;
        i_func          = $urandom_range(0, 3);
        i_length        = $urandom_range(0, 65535);
        i_priority_req  = $urandom_range(0, 1);
        i_data_byte     = $urandom_range(0, 255);
        i_request_limit = $urandom_range(0, 65535);
        i_sink_space    = $urandom_range(0, 65535);
        i_now_ms        = $urandom;
    endtask

    // Insert a random gap between bursts of transfers
    task automatic pace();
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 8)) idle_cycle();
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
    endtask

    // Offer one item and hold it until the block takes it
    task automatic transfer_item(logic [1:0] func, logic [15:0] len, logic crit,
                                 logic [7:0] data, logic [15:0] budget,
                                 logic [15:0] sink, logic [31:0] now);
        pace();
        @(negedge i_clk);
        start           = 1'b1;
        i_func          = func;
        i_length        = len;
        i_priority_req  = crit;
        i_data_byte     = data;
        i_request_limit = budget;
        i_sink_space    = sink;
        i_now_ms        = now;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic header(logic [15:0] len, logic crit);
        transfer_item(FUNC_HEADER, len, crit, $urandom_range(0, 255),
                      $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
    endtask

    task automatic packet_bytes(int count);
        repeat (count)
            transfer_item(FUNC_BYTE, $urandom_range(0, 65535), $urandom_range(0, 1),
                          $urandom_range(0, 255), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom);
    endtask

    task automatic write_try(logic [15:0] budget, logic [15:0] sink, logic [31:0] now);
        transfer_item(FUNC_WRITE, $urandom_range(0, 65535), $urandom_range(0, 1),
                      $urandom_range(0, 255), budget, sink, now);
    endtask

    task automatic clear_ring();
        transfer_item(FUNC_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 1),
                      $urandom_range(0, 255), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom);
    endtask

    // Wait for the admission answer of the header just transferred
    task automatic await_answer(output logic [2:0] answer);
        idle_cycle();
        forever begin
            @(posedge i_clk);
            if (o_strobe && o_kind == KIND_ANSWER) begin
                answer = o_status;
                break;
            end
        end
    endtask

    // Hold off until every due result has come, then let the block go quiet
    task automatic settle(int tail);
        int spins;
        spins = 0;
        do begin
            idle_cycle();
            spins++;
        end while ((results_owed != 0 || busy) && spins < 5000);
        repeat (tail) idle_cycle();
    endtask

    task automatic set_marks(logic [9:0] reserve, logic [9:0] high, logic [9:0] low);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = CFG_IDX_RESERVE;
        i_cfg_wdata = reserve;
        @(negedge i_clk);
        i_cfg_addr  = CFG_IDX_HIGH;
        i_cfg_wdata = high;
        @(negedge i_clk);
        i_cfg_addr  = CFG_IDX_LOW;
        i_cfg_wdata = low;
        // unused index, must leave the marks alone
        @(negedge i_clk);
        i_cfg_addr  = CFG_IDX_SPARE;
        i_cfg_wdata = $urandom_range(0, 1023);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // One random operation: mostly whole packets and drains, some broken traffic
    task automatic random_op();
        int          pick;
        int          len;
        logic        crit;
        logic        blind;
        logic [2:0]  answer;
        logic [15:0] budget;
        logic [15:0] sink;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            len = $urandom_range(0, 99);
            if (len < 70) len = $urandom_range(1, 8);
            else if (len < 85) len = $urandom_range(9, 24);
            else if (len < 93) len = $urandom_range(25, 1023);
            else len = $urandom_range(0, 65535);
            crit  = ($urandom_range(0, 3) == 0);
            blind = (len <= 24) && $urandom_range(0, 1);
            header(len, crit);
            answer = STATUS_ACCEPT;
            if (!blind) await_answer(answer);
            if (answer == STATUS_ACCEPT && len != 0) begin
                // send a few bytes of a long packet and flush it
                if (len > 24) begin
                    packet_bytes($urandom_range(0, 6));
                    clear_ring();
                end else if ($urandom_range(0, 19) == 0) begin
                    // now and then cut a packet short
                    packet_bytes($urandom_range(0, len - 1));
                end else begin
                    packet_bytes(len);
                end
            end
        end else if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) budget = '0;
            else if (pick < 60) budget = $urandom_range(1, 40);
            else budget = $urandom_range(0, 65535);
            pick = $urandom_range(0, 99);
            if (pick < 25) sink = '0;
            else if (pick < 65) sink = $urandom_range(1, 40);
            else sink = $urandom_range(0, 65535);
            if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 200);
            write_try(budget, sink, clock_ms);
        end else if (pick < 85) begin
            clear_ring();
        end else if (pick < 93) begin
            packet_bytes(1);
        end else begin
            header(0, $urandom_range(0, 1));
        end
        if ($urandom_range(0, 49) == 0) settle(4);
    endtask

    task automatic random_phase(logic [9:0] reserve, logic [9:0] high, logic [9:0] low);
        settle(40);
        set_marks(reserve, high, low);
        gaps_on = $urandom_range(0, 3) != 0;
        repeat (PHASE_OPS) random_op();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_marks('0, '0, '0);

        // Directed: admission edges, blocked periods and a full-size request
        header(0, 1'b0);
        write_try(16'hFFFF, 16'hFFFF, 32'h0);
        header(16'hFFFF, 1'b1);
        header(5, 1'b0);
        header(3, 1'b1);
        transfer_item(FUNC_BYTE, '0, 1'b0, 8'h00, '0, '0, '0);
        transfer_item(FUNC_BYTE, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        packet_bytes(3);
        packet_bytes(1);
        write_try(16'h0000, 16'hFFFF, 32'd10);
        write_try(16'hFFFF, 16'h0000, 32'hFFFF_FFF0);
        write_try(16'hFFFF, 16'h0000, 32'h0000_0010);
        header(2, 1'b0);
        header(2, 1'b1);
        packet_bytes(2);
        write_try(16'h0001, 16'hFFFF, 32'h0000_0020);
        write_try(16'hFFFF, 16'h0003, 32'h0000_0030);
        write_try(16'hFFFF, 16'hFFFF, 32'h0000_0040);
        clear_ring();
        header(1023, 1'b0);
        header(1, 1'b1);
        clear_ring();
        header(40, 1'b0);
        packet_bytes(40);
        write_try(16'hFFFF, 16'hFFFF, 32'h8000_0000);
        clear_ring();

        // Random traffic under a spread of watermark settings
        random_phase('0, '0, '0);
        random_phase(10'd1023, '0, 10'd1023);
        random_phase(10'd1022, '0, '0);
        random_phase(10'd10, 10'd24, 10'd8);
        random_phase('0, 10'd1023, 10'd1023);
        random_phase($urandom_range(0, 1023), $urandom_range(1, 1023), $urandom_range(0, 1023));
        random_phase(10'd300, 10'd1, '0);

        settle(40);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
